>>> src/bkol_pkg.sv
// ----------------------------------------------------------------------------
// bkol_pkg
// Shared request codes and controller states of the bounded ordered list.
// ----------------------------------------------------------------------------
package bkol_pkg;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_SEARCH   = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_SH_RD,
    S_SH_WR,
    S_OUT
  } state_e;

endpackage

>>> src/bkol_mem.sv
// ----------------------------------------------------------------------------
// bkol_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bkol_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic signed [31:0] wid_i,
  input  logic [63:0]        wpay_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output logic signed [31:0] rid_o,
  output logic [63:0]        rpay_o
);

  logic [95:0] mem [DEPTH];
  logic [95:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wid_i, wpay_i};
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rid_o  = rdata_q[95:64];
  assign rpay_o = rdata_q[63:0];

endmodule

>>> src/bounded_keyed_ordered_list_top.sv
// ----------------------------------------------------------------------------
// bounded_keyed_ordered_list_top
// Ordered list of keyed entries held in a circular buffer in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with opcode_i, entry_id_i and entry_payload_i; the item is
//   taken at a clock edge where start is high and busy is low. busy stays
//   high until the result has been shown.
//   Each item gives one result, shown for one cycle with done_o high.
//   Steps from the item taken to done_o, with n entries held:
//     inserts, clear, unused codes: done_o in the cycle after the item is taken
//     search hit: a read and a compare for each entry up to the match
//     search or remove without a match: a read and a compare per entry
//     remove hit: a read and a compare for each entry up to the match,
//             then each later entry is read and written
//             back one slot lower through the single memory port pair.
//   The next item may be taken in the cycle after done_o.
//   Reset clears the entry count and head pointer; memory contents are not
//   cleared and never read before written. Results cannot be stalled.
// ----------------------------------------------------------------------------
module bounded_keyed_ordered_list_top #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] entry_id_i,
  input  logic [63:0]        entry_payload_i,
  output logic               done_o,
  output logic               success_o,
  output logic signed [31:0] result_id_o,
  output logic [63:0]        result_payload_o,
  output logic [4:0]         entry_count_o,
  output logic               is_empty_o,
  output logic               is_full_o
);
  import bkol_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic signed [31:0] key_q, key_d;
  logic [AW-1:0] hd_q, hd_d, ptr_q, ptr_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic ok_q, ok_d;
  logic signed [31:0] rid_q, rid_d;
  logic [63:0] rpay_q, rpay_d;

  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] wid, mid;
  logic [63:0]        wpay, mpay;

  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail_ptr;
  logic [CW-1:0] idx_inc;
  logic [CW+4:0] cnt_ext;
  logic          accept;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(CAPACITY - 1) : p - AW'(1);
  endfunction

  bkol_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wid_i   (wid),
    .wpay_i  (wpay),
    .re_i    (re),
    .raddr_i (raddr),
    .rid_o   (mid),
    .rpay_o  (mpay)
  );

  assign accept   = start && (state_q == S_IDLE);
  assign tail_sum = SW'(hd_q) + SW'(cnt_q);
  assign tail_ptr = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY))
                                                : AW'(tail_sum);
  assign idx_inc  = idx_q + CW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_e'(opcode_i) == OP_REMOVE || op_e'(opcode_i) == OP_SEARCH) begin
            state_d = S_RD;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_RD:    state_d = (idx_q == cnt_q) ? S_OUT : S_CMP;
      S_CMP: begin
        if (mid == key_q) begin
          state_d = (op_q == OP_REMOVE) ? S_SH_RD : S_OUT;
        end else begin
          state_d = S_RD;
        end
      end
      S_SH_RD: state_d = (idx_inc == cnt_q) ? S_OUT : S_SH_WR;
      S_SH_WR: state_d = S_SH_RD;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d   = op_q;
    key_d  = key_q;
    hd_d   = hd_q;
    ptr_d  = ptr_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    ok_d   = ok_q;
    rid_d  = rid_q;
    rpay_d = rpay_q;
    we     = 1'b0;
    waddr  = ptr_q;
    wid    = mid;
    wpay   = mpay;
    re     = 1'b0;
    raddr  = ptr_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = op_e'(opcode_i);
          key_d  = entry_id_i;
          ptr_d  = hd_q;
          idx_d  = '0;
          ok_d   = 1'b0;
          rid_d  = '0;
          rpay_d = '0;
          wid    = entry_id_i;
          wpay   = entry_payload_i;
          case (op_e'(opcode_i))
            OP_INS_HEAD: begin
              if (cnt_q != CW'(CAPACITY)) begin
                we    = 1'b1;
                waddr = ptr_dec(hd_q);
                hd_d  = ptr_dec(hd_q);
                cnt_d = cnt_q + CW'(1);
                ok_d  = 1'b1;
              end
            end
            OP_INS_TAIL: begin
              if (cnt_q != CW'(CAPACITY)) begin
                we    = 1'b1;
                waddr = tail_ptr;
                cnt_d = cnt_q + CW'(1);
                ok_d  = 1'b1;
              end
            end
            OP_CLEAR: begin
              cnt_d = '0;
              hd_d  = '0;
              ok_d  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        re    = (idx_q != cnt_q);
        raddr = ptr_q;
      end
      S_CMP: begin
        if (mid == key_q) begin
          ok_d   = 1'b1;
          rid_d  = mid;
          rpay_d = mpay;
        end else begin
          ptr_d = ptr_inc(ptr_q);
          idx_d = idx_inc;
        end
      end
      S_SH_RD: begin
        if (idx_inc == cnt_q) begin
          cnt_d = cnt_q - CW'(1);
        end else begin
          re    = 1'b1;
          raddr = ptr_inc(ptr_q);
        end
      end
      S_SH_WR: begin
        we    = 1'b1;
        waddr = ptr_q;
        ptr_d = ptr_inc(ptr_q);
        idx_d = idx_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      hd_q    <= hd_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    ptr_q  <= ptr_d;
    idx_q  <= idx_d;
    ok_q   <= ok_d;
    rid_q  <= rid_d;
    rpay_q <= rpay_d;
  end

  assign cnt_ext          = {5'b0, cnt_q};
  assign busy             = (state_q != S_IDLE);
  assign done_o           = (state_q == S_OUT);
  assign success_o        = ok_q;
  assign result_id_o      = rid_q;
  assign result_payload_o = rpay_q;
  assign entry_count_o    = cnt_ext[4:0];
  assign is_empty_o       = (cnt_q == '0);
  assign is_full_o        = (cnt_q == CW'(CAPACITY));

endmodule
